// ===== rtl/core/free_list_slot_allocator_top_defines.svh =====
// Assertion macros for the slot allocator.
`ifndef FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define FLSA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FLSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/flsa_pkg.sv =====
package flsa_pkg;

   localparam int ENTRIES_DEFAULT = 64;

   localparam logic OP_RESERVE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== rtl/core/free_list_slot_allocator_top.sv =====
// Slot allocator over ENTRIES slots. A reserve hands out the most recently
// freed slot (slots 0, 1, 2, ... in order after reset); a release returns a
// slot that is in use and is refused for any other index. One word is taken
// at every clock edge where start is high; busy never rises, so a command may
// be issued every cycle. Each word gives one result word, shown for one cycle
// with rsp_strobe; the receiver cannot stall it. The result is formed by the
// registered read of the per-slot in-use memory and then by the free-stack
// update. No clearing pass follows reset.
`include "free_list_slot_allocator_top_defines.svh"

module free_list_slot_allocator_top
   import flsa_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_operation,
   input  logic [IDX_W-1:0] req_entry_index,
   output logic             rsp_strobe,
   output logic             rsp_success,
   output logic [IDX_W-1:0] rsp_granted_index,
   output logic [CNT_W-1:0] rsp_in_use_count
);

   // free stack: top in top_ff, next below in second, the rest in stk_data
   logic [IDX_W-1:0] stk_data [ENTRIES];
   logic             busy_mem [ENTRIES];

   logic             s1_valid_ff;
   logic             s1_op_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic             busy_q_ff;

   logic [IDX_W-1:0] top_ff;
   logic [IDX_W-1:0] sec_mem_ff;
   logic [IDX_W-1:0] sec_reg_ff;
   logic             sec_from_mem_ff;
   logic [CNT_W-1:0] fc_ff;
   logic [CNT_W-1:0] minfc_ff;

   logic             rsp_strobe_ff;
   logic             rsp_success_ff;
   logic [IDX_W-1:0] rsp_granted_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic             accept;
   logic [IDX_W-1:0] second;
   logic             idx_ok;
   logic             idx_written;
   logic             entry_busy;
   logic             do_pop;
   logic             do_push;
   logic [CNT_W-1:0] fc_in;
   logic [CNT_W-1:0] minfc_in;
   logic [IDX_W-1:0] top_in;
   logic [CNT_W-1:0] rd_pos;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_needed;
   logic             rd_unwritten;
   logic [CNT_W-1:0] rd_init;
   logic             stk_we;
   logic [CNT_W-1:0] wr_pos;
   logic [IDX_W-1:0] wr_addr;
   logic             bz_we;
   logic [IDX_W-1:0] bz_addr;
   logic             bz_data;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign second = sec_from_mem_ff ? sec_mem_ff : sec_reg_ff;

   // a slot never reserved since reset has no valid in-use bit in memory
   assign idx_ok      = CNT_W'(s1_idx_ff) < CNT_W'(ENTRIES);
   assign idx_written = CNT_W'(s1_idx_ff) < (CNT_W'(ENTRIES) - minfc_ff);
   assign entry_busy  = idx_ok & idx_written & busy_q_ff;

   assign do_pop  = s1_valid_ff & (s1_op_ff == OP_RESERVE) & (fc_ff != '0);
   assign do_push = s1_valid_ff & (s1_op_ff == OP_RELEASE) & entry_busy;

   always_comb begin
      if (do_pop) begin
         fc_in  = fc_ff - CNT_W'(1);
         top_in = second;
      end else if (do_push) begin
         fc_in  = fc_ff + CNT_W'(1);
         top_in = s1_idx_ff;
      end else begin
         fc_in  = fc_ff;
         top_in = top_ff;
      end
   end

   assign minfc_in = (fc_in < minfc_ff) ? fc_in : minfc_ff;

   // stack positions below minfc-1 were never written; their reset-order contents come from rd_init
   assign rd_pos       = fc_in - CNT_W'(2);
   assign rd_addr      = rd_pos[IDX_W-1:0];
   assign rd_needed    = do_pop & (fc_in >= CNT_W'(2));
   assign rd_unwritten = (fc_in - CNT_W'(1)) < minfc_in;
   assign rd_init      = CNT_W'(ENTRIES - 1) - rd_pos;

   assign stk_we  = do_push & (fc_ff != '0);
   assign wr_pos  = fc_ff - CNT_W'(1);
   assign wr_addr = wr_pos[IDX_W-1:0];

   assign bz_we   = do_pop | do_push;
   assign bz_addr = do_pop ? top_ff : s1_idx_ff;
   assign bz_data = do_pop;

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_data[wr_addr] <= top_ff;
      end
      if (rd_needed && !rd_unwritten) begin
         sec_mem_ff <= stk_data[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bz_we) begin
         busy_mem[bz_addr] <= bz_data;
      end
      if (accept) begin
         if (bz_we && bz_addr == req_entry_index) begin
            busy_q_ff <= bz_data;
         end else begin
            busy_q_ff <= busy_mem[req_entry_index];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         fc_ff           <= CNT_W'(ENTRIES);
         minfc_ff        <= CNT_W'(ENTRIES);
         top_ff          <= '0;
         sec_reg_ff      <= IDX_W'(1);
         sec_from_mem_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         fc_ff         <= fc_in;
         minfc_ff      <= minfc_in;
         top_ff        <= top_in;
         rsp_strobe_ff <= s1_valid_ff;
         if (rd_needed) begin
            sec_from_mem_ff <= ~rd_unwritten;
            sec_reg_ff      <= rd_init[IDX_W-1:0];
         end else if (do_push) begin
            sec_from_mem_ff <= 1'b0;
            sec_reg_ff      <= top_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= req_operation;
         s1_idx_ff <= req_entry_index;
      end
      rsp_success_ff <= do_pop | do_push;
      rsp_granted_ff <= do_pop ? top_ff : '0;
      rsp_count_ff   <= CNT_W'(ENTRIES) - fc_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_in_use_count  = rsp_count_ff;

   `FLSA_ASSERT_NOW(a_count_matches_stack, rsp_strobe, rsp_in_use_count == CNT_W'(ENTRIES) - fc_ff, "in-use count disagrees with free stack depth")
   `FLSA_ASSERT_NOW(a_low_mark_bound, 1'b1, minfc_ff <= fc_ff, "free low mark above free count")
   `FLSA_ASSERT_NOW(a_grant_zero_on_fail, rsp_strobe && !rsp_success, rsp_granted_index == '0, "nonzero grant on refused word")
   `FLSA_ASSERT_NEXT(a_result_latency, start && !busy, ##1 rsp_strobe, "accepted word gave no result")

endmodule
